### rtl/ptfl_pkg.sv
// ----------------------------------------------------------------------------
// ptfl_pkg: shared types and constants for the page translation block
// Register indexes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ptfl_pkg;

  localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] CFG_FRAME_COUNT = 2'd1;
  localparam logic [1:0] CFG_POLICY      = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOOK  = 7'b0000010,
    ST_AGE   = 7'b0000100,
    ST_VICT  = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_DONE  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

endpackage

### rtl/page_translate_fifo_lru_core.sv
// ----------------------------------------------------------------------------
// page_translate_fifo_lru_core: inverted page table with FIFO / LRU aging
// Translates logical addresses through a frame table held in memory.
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// s_axis   in         tvalid/tready       tdata: logical_address, tuser: write flag
// m_axis   out        tvalid/tready       tdata: phys, frame, hit, evicted, totals
// cfg      in         cfg_we_i            cfg_idx_i, cfg_data_i
//
// One item at a time. Lookup scans frames one per cycle and stops at the first
// hit; aging sweeps N frames on a tick wrap after a hit or under LRU, and an LRU
// eviction scans N ages. After a frame count write a stale tick is reduced
// modulo N, in steps of N, before the next item is taken. After reset a clearing
// pass over all MAX_FRAMES entries clears valid bits and ages. The result waits
// in an output register.
module page_translate_fifo_lru_core
  import ptfl_pkg::*;
#(
  parameter int MAX_FRAMES = 256,
  parameter int ADDR_BITS  = 32,
  parameter int AGE_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // logical_address
  input  logic [ADDR_BITS-1:0]  s_axis_tdata,
  // write flag
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // physical_address[31:0], frame_index[39:32], hit[40], evicted[41],
  // fault_total[73:42], swap_in_total[105:74], swap_out_total[137:106], pad
  output logic [143:0]          m_axis_tdata
);

  localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int PW = ADDR_BITS - 1;
  localparam int EW = PW + 1 + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // memory entry: page, valid, age
  logic [EW-1:0] mem [MAX_FRAMES];
  logic [EW-1:0] rd_q;
  logic [FW-1:0] raddr;
  logic          we;
  logic [FW-1:0] waddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [PW-1:0]       rd_page;
  logic                rd_val;
  logic [AGE_BITS-1:0] rd_age;
  assign rd_page = rd_q[EW-1 -: PW];
  assign rd_val  = rd_q[AGE_BITS];
  assign rd_age  = rd_q[AGE_BITS-1:0];

  state_e state_q, state_d;
  logic [4:0] offs_q;
  logic [8:0] fcnt_q;
  logic       pol_q;
  logic [CW-1:0] n;
  logic [4:0]    sw;

  always_comb begin
    if (fcnt_q == 9'd0) n = CW'(1);
    else if (32'(fcnt_q) > MAX_FRAMES) n = CW'(MAX_FRAMES);
    else n = CW'(fcnt_q);
  end
  assign sw = (offs_q == 5'd0) ? 5'd1 : offs_q;

  logic             clr_q;
  logic [CW-1:0]    clr_cnt_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic             wr_q;
  logic [CW-1:0]    cnt_q, cnt_d;    // address issued
  logic             rv_q, rv_d;      // read data valid this cycle
  logic [FW-1:0]    ra_q, ra_d;      // address of rd_q
  logic             hit_q, hit_d, free_q, free_d, ev_q, ev_d;
  logic [FW-1:0]    frame_q, frame_d, free_f_q, free_f_d;
  logic [AGE_BITS-1:0] best_q, best_d;
  logic [7:0]       tick_q, tick_d, fifo_q, fifo_d;
  logic [31:0]      flt_q, flt_d, sin_q, sin_d, sout_q, sout_d;
  logic             age_do_q, age_do_d;
  logic             ov_q;
  logic [143:0]     od_q;

  logic [PW-1:0] page;
  assign page = PW'(addr_q >> sw);

  logic [7:0] tick_nx;
  always_comb begin
    if (32'(tick_q) + 1 >= 32'(n)) tick_nx = 8'd0;
    else tick_nx = tick_q + 8'd1;
  end

  logic [AGE_BITS-1:0] age_inc;
  assign age_inc = (rd_age == AGE_MAX) ? rd_age : rd_age + 1'b1;

  assign s_axis_tready = (state_q == ST_IDLE) && !clr_q && !ov_q && (CW'(tick_q) < n);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; rv_d = 1'b0; ra_d = ra_q;
    hit_d = hit_q; free_d = free_q; ev_d = ev_q;
    frame_d = frame_q; free_f_d = free_f_q; best_d = best_q;
    tick_d = tick_q; fifo_d = fifo_q;
    flt_d = flt_q; sin_d = sin_q; sout_d = sout_q; age_do_d = age_do_q;
    raddr = '0; we = 1'b0; waddr = '0; wdata = '0;
    if (clr_q) begin
      we = 1'b1; waddr = FW'(clr_cnt_q);
    end
    case (state_q)
      ST_IDLE: begin
        // stale tick after a frame count write: reduce modulo N
        if (CW'(tick_q) >= n) begin
          tick_d = tick_q - 8'(n);
        end else if (s_axis_tvalid && s_axis_tready) begin
          state_d = ST_LOOK; cnt_d = '0;
          hit_d = 1'b0; free_d = 1'b0; ev_d = 1'b0;
        end
      end
      ST_LOOK: begin
        if (rv_q) begin
          if (rd_val && rd_page == page) begin
            hit_d = 1'b1; frame_d = ra_q;
          end else if (!rd_val && !free_q) begin
            free_d = 1'b1; free_f_d = ra_q;
          end
        end
        if ((rv_q && rd_val && rd_page == page) || (!rv_q && cnt_q == n)) begin
          // finish lookup
          if (!(rv_q && rd_val && rd_page == page)) begin
            flt_d = flt_q + 32'd1; sin_d = sin_q + 32'd1;
            if (wr_q) sout_d = sout_q + 32'd1;
          end
          tick_d = tick_nx;
          age_do_d = (tick_nx == 8'd0) &&
                     ((rv_q && rd_val && rd_page == page) || pol_q);
          cnt_d = '0; state_d = ST_AGE;
        end else if (cnt_q < n) begin
          raddr = FW'(cnt_q); ra_d = FW'(cnt_q); rv_d = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_AGE: begin
        // read-modify-write sweep; write in the cycle after the read
        if (rv_q) begin
          we = 1'b1; waddr = ra_q; wdata = {rd_page, rd_val, age_inc};
        end
        if (!age_do_q) begin
          cnt_d = '0; best_d = '0; frame_d = hit_q ? frame_q : '0;
          if (hit_q || free_q || !pol_q) state_d = ST_WRITE;
          else state_d = ST_VICT;
        end else if (cnt_q < n) begin
          raddr = FW'(cnt_q); ra_d = FW'(cnt_q); rv_d = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else if (!rv_q) begin
          age_do_d = 1'b0;
        end
      end
      ST_VICT: begin
        if (rv_q && rd_age > best_q) begin
          best_d = rd_age; frame_d = ra_q;
        end
        if (cnt_q < n) begin
          raddr = FW'(cnt_q); ra_d = FW'(cnt_q); rv_d = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else if (!rv_q) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (hit_q) begin
          raddr = frame_q; state_d = ST_DONE;
        end else begin
          if (free_q) begin
            we = 1'b1;
            frame_d = free_f_q; waddr = free_f_q;
            wdata = {page, 1'b1, {AGE_BITS{1'b0}}};
          end else if (pol_q) begin
            we = 1'b1;
            ev_d = 1'b1; waddr = frame_q;
            wdata = {page, 1'b1, {AGE_BITS{1'b0}}};
          end else begin
            ev_d = 1'b1;
            if (32'(fifo_q) >= 32'(n)) begin
              frame_d = '0;
              fifo_d = (n == CW'(1)) ? 8'd0 : 8'd1;
            end else begin
              frame_d = FW'(fifo_q);
              fifo_d = (32'(fifo_q) + 1 >= 32'(n)) ? 8'd0 : fifo_q + 8'd1;
            end
            raddr = frame_d;
          end
          state_d = (free_q || pol_q) ? ST_OUT : ST_DONE;
        end
      end
      ST_DONE: begin
        // hit: clear age; FIFO evict: new page, keep age
        we = 1'b1; waddr = frame_q;
        if (hit_q) wdata = {rd_page, rd_val, {AGE_BITS{1'b0}}};
        else       wdata = {page, 1'b1, rd_age};
        state_d = ST_OUT;
      end
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic [ADDR_BITS-1:0] off_mask;
  logic [31:0] phys;
  assign off_mask = (ADDR_BITS'(1) << sw) - 1'b1;
  assign phys = 32'((ADDR_BITS'(frame_q) << sw) | (addr_q & off_mask));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      offs_q <= 5'd12; fcnt_q <= 9'd256; pol_q <= 1'b0;
      clr_q <= 1'b1; clr_cnt_q <= '0;
      cnt_q <= '0; rv_q <= 1'b0; ra_q <= '0;
      hit_q <= 1'b0; free_q <= 1'b0; ev_q <= 1'b0;
      frame_q <= '0; free_f_q <= '0; best_q <= '0;
      tick_q <= '0; fifo_q <= '0;
      flt_q <= '0; sin_q <= '0; sout_q <= '0; age_do_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; rv_q <= rv_d; ra_q <= ra_d;
      hit_q <= hit_d; free_q <= free_d; ev_q <= ev_d;
      frame_q <= frame_d; free_f_q <= free_f_d; best_q <= best_d;
      tick_q <= tick_d; fifo_q <= fifo_d;
      flt_q <= flt_d; sin_q <= sin_d; sout_q <= sout_d; age_do_q <= age_do_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == CW'(MAX_FRAMES - 1)) clr_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OFFSET_BITS: offs_q <= cfg_data_i[4:0];
          CFG_FRAME_COUNT: fcnt_q <= cfg_data_i;
          CFG_POLICY:      pol_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == ST_OUT) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      addr_q <= s_axis_tdata; wr_q <= s_axis_tuser;
    end
    if (state_q == ST_OUT)
      od_q <= {6'd0, sout_q, sin_q, flt_q, ev_q, hit_q, 8'(frame_q), phys};
  end

endmodule

### rtl/ptfl_checker.sv
// ----------------------------------------------------------------------------
// ptfl_checker: port-level checks for the page translation block
// Watches the stream ports over time.
// ----------------------------------------------------------------------------
module ptfl_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata
);

  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[40] && m_axis_tdata[41]))
    else $error("hit and evict together");

  a_accept_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");

endmodule

bind page_translate_fifo_lru_core ptfl_checker u_ptfl_checker (.*);
